// ===== rtl/core/framed_wide_operand_stack_macros.svh =====
// ---------------------------------------------------------------------------
// framed wide operand stack assertion macros
// concurrent checks that vanish when built for synthesis
// ---------------------------------------------------------------------------
`ifndef FRAMED_WIDE_OPERAND_STACK_MACROS_SVH
`define FRAMED_WIDE_OPERAND_STACK_MACROS_SVH

`ifndef SYNTHESIS

`define FWOS_ASSERT(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("fwos check failed");

`define FWOS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fwos check failed");

`else

`define FWOS_ASSERT(name, clk, rst, expr)

`define FWOS_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/fwos_pkg.sv =====
// ---------------------------------------------------------------------------
// fwos_pkg
// types and codes shared by the framed wide operand stack
// ---------------------------------------------------------------------------
`default_nettype none

package fwos_pkg;

   localparam int LIMB_W         = 64;
   localparam int LIMBS          = 4;
   localparam int WORD_W         = LIMB_W * LIMBS;
   localparam int HEIGHT_W       = 11;
   localparam int OP_W           = 4;
   localparam int PROTOCOL_LIMIT = 1024;

   typedef enum logic [OP_W-1:0] {
      OP_RESET      = 4'd0,
      OP_FRAME_PUSH = 4'd1,
      OP_FRAME_POP  = 4'd2,
      OP_PUSH       = 4'd3,
      OP_POP        = 4'd4,
      OP_PEEK       = 4'd5,
      OP_SET        = 4'd6,
      OP_VALIDATE   = 4'd7,
      OP_REWRITE    = 4'd8,
      OP_DUP        = 4'd9,
      OP_SWAP       = 4'd10,
      OP_EXCHANGE   = 4'd11
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_UNDER = 2'd1,
      ST_OVER  = 2'd2,
      ST_FRAME = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_READ,
      S_DUP,
      S_SWAP_A,
      S_SWAP_B,
      S_SWAP_C,
      S_HLOAD
   } state_type;

   typedef struct packed {
      op_type              op;
      logic [LIMB_W-1:0]   word_limb0;
      logic [LIMB_W-1:0]   word_limb1;
      logic [LIMB_W-1:0]   word_limb2;
      logic [LIMB_W-1:0]   word_limb3;
      logic [HEIGHT_W-1:0] first_count;
      logic [HEIGHT_W-1:0] second_count;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [LIMB_W-1:0]   out_limb0;
      logic [LIMB_W-1:0]   out_limb1;
      logic [LIMB_W-1:0]   out_limb2;
      logic [LIMB_W-1:0]   out_limb3;
      logic [HEIGHT_W-1:0] height_now;
      logic [HEIGHT_W-1:0] base_row;
   } rsp_type;

   typedef struct packed {
      status_type          status;
      logic                hit;
      logic [HEIGHT_W-1:0] row_l;
      logic [HEIGHT_W-1:0] row_r;
      logic [HEIGHT_W-1:0] height_next;
      logic [HEIGHT_W-1:0] base;
   } eval_type;

endpackage

`default_nettype wire

// ===== rtl/core/fwos_ram.sv =====
// ---------------------------------------------------------------------------
// fwos_ram
// generic simple dual-port ram, one write port and one registered read port
// ---------------------------------------------------------------------------
`default_nettype none

module fwos_ram #(
   parameter  int WIDTH  = 8,
   parameter  int DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/core/fwos_eval.sv =====
// ---------------------------------------------------------------------------
// fwos_eval
// bounds checks, row offsets and new height for one stack op
// ---------------------------------------------------------------------------
`default_nettype none

module fwos_eval import fwos_pkg::*; (
   input  wire op_type              op,
   input  wire logic [HEIGHT_W-1:0] height,
   input  wire logic [HEIGHT_W-1:0] first_count,
   input  wire logic [HEIGHT_W-1:0] second_count,
   input  wire logic [HEIGHT_W-1:0] limit,
   output eval_type                 ev
);

   logic [HEIGHT_W:0] h_x;
   logic [HEIGHT_W:0] a_x;
   logic [HEIGHT_W:0] b_x;
   logic [HEIGHT_W:0] lim_x;
   logic [HEIGHT_W:0] l_x;
   logic [HEIGHT_W:0] r_x;
   logic [HEIGHT_W:0] need_x;
   logic [HEIGHT_W:0] kept_x;
   status_type        effect;

   always_comb begin
      h_x    = {1'b0, height};
      a_x    = {1'b0, first_count};
      b_x    = {1'b0, second_count};
      lim_x  = {1'b0, limit};
      l_x    = (op == OP_SWAP) ? '0 : a_x;
      r_x    = (op == OP_SWAP) ? a_x : b_x;
      need_x = (l_x > r_x) ? l_x : r_x;
      kept_x = h_x - a_x;

      if (h_x < a_x) begin
         effect = ST_UNDER;
      end else if (b_x > lim_x - kept_x) begin
         effect = ST_OVER;
      end else begin
         effect = ST_OK;
      end

      ev.status      = ST_OK;
      ev.hit         = 1'b0;
      ev.row_l       = '0;
      ev.row_r       = '0;
      ev.height_next = height;
      ev.base        = '0;

      unique case (op)
         OP_PUSH: begin
            if (h_x >= lim_x) begin
               ev.status = ST_OVER;
            end else begin
               ev.hit         = 1'b1;
               ev.row_l       = height;
               ev.height_next = HEIGHT_W'(h_x + 1'b1);
            end
         end
         OP_POP: begin
            if (h_x == '0) begin
               ev.status = ST_UNDER;
            end else begin
               ev.hit         = 1'b1;
               ev.row_l       = HEIGHT_W'(h_x - 1'b1);
               ev.height_next = HEIGHT_W'(h_x - 1'b1);
            end
         end
         OP_PEEK: begin
            if (a_x < h_x) begin
               ev.hit   = 1'b1;
               ev.row_l = HEIGHT_W'(h_x - 1'b1 - a_x);
            end
         end
         OP_SET: begin
            if (a_x >= h_x) begin
               ev.status = ST_UNDER;
            end else begin
               ev.hit   = 1'b1;
               ev.row_l = HEIGHT_W'(h_x - 1'b1 - a_x);
            end
         end
         OP_VALIDATE: begin
            ev.status = effect;
         end
         OP_REWRITE: begin
            ev.status = effect;
            if (effect == ST_OK) begin
               ev.hit         = 1'b1;
               ev.base        = HEIGHT_W'(kept_x);
               ev.height_next = HEIGHT_W'(kept_x + b_x);
            end
         end
         OP_DUP: begin
            if (a_x == '0 || h_x < a_x) begin
               ev.status = ST_UNDER;
            end else if (h_x >= lim_x) begin
               ev.status = ST_OVER;
            end else begin
               ev.hit         = 1'b1;
               ev.row_l       = HEIGHT_W'(kept_x);
               ev.row_r       = height;
               ev.height_next = HEIGHT_W'(h_x + 1'b1);
            end
         end
         OP_SWAP, OP_EXCHANGE: begin
            if (need_x >= h_x) begin
               ev.status = ST_UNDER;
            end else begin
               ev.hit   = 1'b1;
               ev.row_l = HEIGHT_W'(h_x - 1'b1 - l_x);
               ev.row_r = HEIGHT_W'(h_x - 1'b1 - r_x);
            end
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/framed_wide_operand_stack.sv =====
// ---------------------------------------------------------------------------
// framed_wide_operand_stack
// per-frame stack of 256-bit words held in a word ram, saved frame heights
// in a second ram, one op per item and one result per item
// ---------------------------------------------------------------------------
//
// channel   direction  handshake                 payload
// request   in         start high, busy low      req_item (req_type)
// result    out        rsp_strobe, one cycle     rsp_item (rsp_type)
//
// reset, frame push, push, set, validate, rewrite, unused ops, peek out of
// range and any op that fails its checks: finished in the exec state
// pop, peek, frame pop and dup that go ahead: exec, then a read, dup or
// height load state that takes the registered ram read
// swap and exchange in range: exec and swap states a, b and c, two reads
// and two writes on the single read and single write port of the word ram
// the result is registered and shows in the cycle after the last state of
// work, while a new item may already be taken; results cannot be held off
// reset is synchronous; the rams need no clearing pass
//
`default_nettype none

`include "framed_wide_operand_stack_macros.svh"

module framed_wide_operand_stack import fwos_pkg::*; #(
   parameter int FRAME_WORDS = 1024,
   parameter int FRAME_COUNT = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   output logic         rsp_strobe,
   output rsp_type      rsp_item
);

   localparam int LIMIT  = (FRAME_WORDS < PROTOCOL_LIMIT) ? FRAME_WORDS : PROTOCOL_LIMIT;
   localparam int ROWS   = FRAME_COUNT * FRAME_WORDS;
   localparam int AW     = $clog2(ROWS);
   localparam int LW     = $clog2(FRAME_COUNT);

   state_type           state_ff, state_in;
   req_type             req_ff, req_in;
   logic [HEIGHT_W-1:0] h_ff, h_in;
   logic [LW-1:0]       level_ff, level_in;
   logic [AW-1:0]       fbase_ff, fbase_in;
   logic [WORD_W-1:0]   t_ff, t_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_strobe_ff, rsp_strobe_in;

   logic                w_wr_en;
   logic [AW-1:0]       w_wr_addr;
   logic [WORD_W-1:0]   w_wr_data;
   logic [AW-1:0]       w_rd_addr;
   logic [WORD_W-1:0]   w_rd_data;

   logic                h_wr_en;
   logic [LW-1:0]       h_wr_addr;
   logic [HEIGHT_W-1:0] h_wr_data;
   logic [LW-1:0]       h_rd_addr;
   logic [HEIGHT_W-1:0] h_rd_data;

   eval_type            ev;
   logic [WORD_W-1:0]   req_word;
   logic [AW-1:0]       addr_l;
   logic [AW-1:0]       addr_r;
   logic                last_frame;

   fwos_eval u_eval (
      .op           (req_ff.op),
      .height       (h_ff),
      .first_count  (req_ff.first_count),
      .second_count (req_ff.second_count),
      .limit        (HEIGHT_W'(LIMIT)),
      .ev           (ev)
   );

   fwos_ram #(
      .WIDTH (WORD_W),
      .DEPTH (ROWS)
   ) u_word_ram (
      .clock   (clock),
      .wr_en   (w_wr_en),
      .wr_addr (w_wr_addr),
      .wr_data (w_wr_data),
      .rd_addr (w_rd_addr),
      .rd_data (w_rd_data)
   );

   fwos_ram #(
      .WIDTH (HEIGHT_W),
      .DEPTH (FRAME_COUNT)
   ) u_height_ram (
      .clock   (clock),
      .wr_en   (h_wr_en),
      .wr_addr (h_wr_addr),
      .wr_data (h_wr_data),
      .rd_addr (h_rd_addr),
      .rd_data (h_rd_data)
   );

   assign req_word   = {req_ff.word_limb3, req_ff.word_limb2,
                        req_ff.word_limb1, req_ff.word_limb0};
   assign addr_l     = fbase_ff + AW'(ev.row_l);
   assign addr_r     = fbase_ff + AW'(ev.row_r);
   assign last_frame = ({1'b0, level_ff} + 1'b1) >= (LW+1)'(FRAME_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         h_ff          <= '0;
         level_ff      <= '0;
         fbase_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         h_ff          <= h_in;
         level_ff      <= level_in;
         fbase_ff      <= fbase_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      t_ff   <= t_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      h_in          = h_ff;
      level_in      = level_ff;
      fbase_in      = fbase_ff;
      t_in          = t_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      busy          = (state_ff != S_IDLE);

      w_wr_en   = 1'b0;
      w_wr_addr = addr_l;
      w_wr_data = req_word;
      w_rd_addr = addr_l;
      h_wr_en   = 1'b0;
      h_wr_addr = level_ff;
      h_wr_data = h_ff;
      h_rd_addr = level_ff - 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_item;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            rsp_in.status     = ev.status;
            rsp_in.out_limb0  = '0;
            rsp_in.out_limb1  = '0;
            rsp_in.out_limb2  = '0;
            rsp_in.out_limb3  = '0;
            rsp_in.height_now = ev.height_next;
            rsp_in.base_row   = ev.base;
            rsp_strobe_in     = 1'b1;
            state_in          = S_IDLE;
            unique case (req_ff.op)
               OP_RESET: begin
                  level_in          = '0;
                  fbase_in          = '0;
                  h_in              = '0;
                  rsp_in.height_now = '0;
               end
               OP_FRAME_PUSH: begin
                  if (last_frame) begin
                     rsp_in.status = ST_FRAME;
                  end else begin
                     h_wr_en           = 1'b1;
                     level_in          = level_ff + 1'b1;
                     fbase_in          = fbase_ff + AW'(FRAME_WORDS);
                     h_in              = '0;
                     rsp_in.height_now = '0;
                  end
               end
               OP_FRAME_POP: begin
                  if (level_ff == '0) begin
                     rsp_in.status = ST_FRAME;
                  end else begin
                     level_in      = level_ff - 1'b1;
                     fbase_in      = fbase_ff - AW'(FRAME_WORDS);
                     rsp_strobe_in = 1'b0;
                     state_in      = S_HLOAD;
                  end
               end
               OP_PUSH, OP_SET: begin
                  w_wr_en = ev.hit;
                  h_in    = ev.height_next;
               end
               OP_POP, OP_PEEK: begin
                  h_in = ev.height_next;
                  if (ev.hit) begin
                     rsp_strobe_in = 1'b0;
                     state_in      = S_READ;
                  end
               end
               OP_REWRITE: begin
                  h_in = ev.height_next;
               end
               OP_DUP: begin
                  if (ev.hit) begin
                     rsp_strobe_in = 1'b0;
                     state_in      = S_DUP;
                  end
               end
               OP_SWAP, OP_EXCHANGE: begin
                  if (ev.hit) begin
                     rsp_strobe_in = 1'b0;
                     state_in      = S_SWAP_A;
                  end
               end
               default: begin
               end
            endcase
         end
         S_READ: begin
            rsp_in.out_limb0 = w_rd_data[0*LIMB_W +: LIMB_W];
            rsp_in.out_limb1 = w_rd_data[1*LIMB_W +: LIMB_W];
            rsp_in.out_limb2 = w_rd_data[2*LIMB_W +: LIMB_W];
            rsp_in.out_limb3 = w_rd_data[3*LIMB_W +: LIMB_W];
            rsp_strobe_in    = 1'b1;
            state_in         = S_IDLE;
         end
         S_DUP: begin
            w_wr_en       = 1'b1;
            w_wr_addr     = addr_r;
            w_wr_data     = w_rd_data;
            h_in          = ev.height_next;
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end
         S_SWAP_A: begin
            t_in      = w_rd_data;
            w_rd_addr = addr_r;
            state_in  = S_SWAP_B;
         end
         S_SWAP_B: begin
            w_wr_en   = 1'b1;
            w_wr_addr = addr_l;
            w_wr_data = w_rd_data;
            state_in  = S_SWAP_C;
         end
         S_SWAP_C: begin
            w_wr_en       = 1'b1;
            w_wr_addr     = addr_r;
            w_wr_data     = t_ff;
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end
         S_HLOAD: begin
            h_in              = h_rd_data;
            rsp_in.height_now = h_rd_data;
            rsp_strobe_in     = 1'b1;
            state_in          = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   `FWOS_ASSERT_NEXT(a_accept_goes_busy, clock, reset, start && !busy, busy)
   `FWOS_ASSERT(a_strobe_after_work, clock, reset, !rsp_strobe || $past(busy))
   `FWOS_ASSERT(a_height_in_limit, clock, reset, h_ff <= HEIGHT_W'(LIMIT))
   `FWOS_ASSERT(a_frame_zero_base, clock, reset, (level_ff != '0) || (fbase_ff == '0))

endmodule

`default_nettype wire
